// ----- design/bia_pkg.sv -----
// ----------------------------------------------------------------------------
// bia_pkg
// Shared types, codes and helpers for the bitmap id allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_OCCUPY = 2'd2,
        ACT_QUERY  = 2'd3
    } t_action;

    localparam logic [1:0] CFG_ID_COUNT  = 2'd0;
    localparam logic [1:0] CFG_BUSY_THR  = 2'd1;
    localparam logic [1:0] CFG_HEADROOM  = 2'd2;

    localparam logic [14:0] RST_ID_COUNT = 15'd16384;
    localparam logic [15:0] RST_BUSY_THR = 16'd10240;
    localparam logic [15:0] RST_HEADROOM = 16'd1024;

    localparam logic [14:0] COUNT_MAX = 15'h7fff;

    // live configuration seen by the back end
    typedef struct packed {
        logic [14:0] eff_ids;
        logic [15:0] busy_thr;
        logic [15:0] headroom;
    } t_cfg;

    // classified command passed through the queue
    typedef struct packed {
        t_action     action;
        logic [13:0] tid;
        logic        in_range;
        logic        n_zero;
        logic        chk;
        logic [14:0] lim;
    } t_cmd;

    function automatic logic [5:0] lowest_bit(input logic [63:0] v);
        logic [5:0] r;
        r = 6'd63;
        for (int i = 63; i >= 0; i--) begin
            if (v[i]) begin
                r = 6'(i);
            end
        end
        return r;
    endfunction

endpackage

// ----- design/bia_fifo.sv -----
// ----------------------------------------------------------------------------
// bia_fifo
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module bia_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bia_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output bia_pkg::t_cmd o_cmd
);
    import bia_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- design/bia_front.sv -----
// ----------------------------------------------------------------------------
// bia_front
// Configuration registers, input handshake and command classification.
// ----------------------------------------------------------------------------
module bia_front #(
    parameter int MAX_IDS = 16384
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_action,
    input  logic [13:0]   i_target_id,
    input  logic [14:0]   i_alloc_limit,
    input  logic          i_full,
    input  logic          i_init_busy,
    output logic          o_push,
    output bia_pkg::t_cmd o_cmd,
    output bia_pkg::t_cfg o_cfg,
    output logic          o_init_req
);
    import bia_pkg::*;

    logic [14:0] r_id_count;
    logic [15:0] r_busy_thr;
    logic [15:0] r_headroom;
    logic        r_init_req;
    logic [14:0] eff;
    logic [14:0] lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_count <= RST_ID_COUNT;
            r_busy_thr <= RST_BUSY_THR;
            r_headroom <= RST_HEADROOM;
            r_init_req <= 1'b0;
        end else begin
            r_init_req <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ID_COUNT: begin
                        r_id_count <= i_cfg_data[14:0];
                        r_init_req <= 1'b1;
                    end
                    CFG_BUSY_THR: r_busy_thr <= i_cfg_data;
                    CFG_HEADROOM: r_headroom <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign eff = (17'(r_id_count) > 17'(MAX_IDS)) ? 15'(MAX_IDS) : r_id_count;

    // a zero or oversized limit means the whole id range
    assign lim = (i_alloc_limit == 15'd0 || i_alloc_limit > eff) ? eff : i_alloc_limit;

    always_comb begin
        o_cmd.action   = t_action'(i_action);
        o_cmd.tid      = i_target_id;
        o_cmd.in_range = ({1'b0, i_target_id} < eff);
        o_cmd.n_zero   = (eff == 15'd0);
        o_cmd.chk      = ({1'b0, lim} > r_busy_thr) && (lim[14:6] != 9'd0);
        o_cmd.lim      = lim;
    end

    assign o_cfg      = '{eff_ids: eff, busy_thr: r_busy_thr, headroom: r_headroom};
    assign o_init_req = r_init_req;
    assign o_in_ready = !i_full && !i_init_busy && !r_init_req;
    assign o_push     = i_in_valid && o_in_ready;

endmodule

// ----- design/bia_back.sv -----
// ----------------------------------------------------------------------------
// bia_back
// Bitmap memory, allocation scan sequencer and result register.
// ----------------------------------------------------------------------------
module bia_back #(
    parameter int MAX_IDS = 16384
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bia_pkg::t_cfg i_cfg,
    input  logic          i_init_req,
    output logic          o_init_busy,
    input  logic          i_cmd_valid,
    input  bia_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [13:0]   o_granted_id,
    output logic          o_granted,
    output logic          o_occupied
);
    import bia_pkg::*;

    localparam int NWORDS = (MAX_IDS + 63) / 64;
    localparam int WIDX   = (NWORDS > 1) ? $clog2(NWORDS) : 1;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_DISP, S_CHK, S_MOD, S_SCAN, S_PART, S_OP
    } t_state;

    logic [63:0] mem [NWORDS];
    logic [63:0] r_rdata;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [WIDX-1:0]   r_init_idx, n_init_idx;
    logic [WIDX-1:0]   r_cur, n_cur;
    logic [WIDX-1:0]   r_next0, n_next0;
    logic [WIDX-1:0]   r_last, n_last;
    logic [9:0]        r_cnt, n_cnt;
    logic              r_first, n_first;
    logic [10:0]       r_rem, n_rem;
    logic [3:0]        r_k, n_k;
    logic [14:0]       r_count, n_count;
    logic              r_out_valid, n_out_valid;
    logic [13:0]       r_granted_id, n_granted_id;
    logic              r_granted, n_granted;
    logic              r_occupied, n_occupied;

    logic              rd_en, we;
    logic [WIDX-1:0]   rd_addr, wa;
    logic [63:0]       wd;
    logic              pop, fin, do_scan, do_part;
    logic [8:0]        nfull;
    logic [5:0]        rem;
    logic              partial_ok;
    logic [14:0]       count_inc;
    logic [15:0]       lw1;
    logic [20:0]       sub_val;
    logic [10:0]       rem_step;
    logic [5:0]        bit_sel;
    logic [63:0]       pmask;
    logic [63:0]       masked;
    logic [15:0]       next_lin;
    logic [15:0]       gap;
    logic              refuse;
    logic [63:0]       init_word;
    logic [17:0]       base;

    assign nfull      = r_cmd.lim[14:6];
    assign rem        = r_cmd.lim[5:0];
    assign partial_ok = (rem != 6'd0) && (16'(nfull) < 16'(NWORDS));
    assign count_inc  = (r_count == COUNT_MAX) ? r_count : r_count + 15'd1;
    assign lw1        = 16'(r_last) + 16'd1;
    assign sub_val    = 21'(nfull) << r_k;
    assign rem_step   = (21'(r_rem) >= sub_val) ? 11'(21'(r_rem) - sub_val) : r_rem;
    assign pmask      = (64'd1 << rem) - 64'd1;
    assign masked     = r_rdata & pmask;
    assign next_lin   = 16'(r_cur) + 16'd1;
    assign gap        = (r_cmd.lim > r_count) ? 16'(r_cmd.lim - r_count)
                                              : 16'(r_count - r_cmd.lim);
    assign refuse     = (r_rdata == 64'd0)
                      && ((gap < i_cfg.headroom && r_cmd.lim != i_cfg.eff_ids)
                          || r_count == i_cfg.eff_ids);

    // reset content of one bitmap word for the current id count
    always_comb begin
        base = 18'(r_init_idx) << 6;
        if (base + 18'd64 <= 18'(i_cfg.eff_ids)) begin
            init_word = '1;
        end else if (base < 18'(i_cfg.eff_ids)) begin
            init_word = (64'd1 << 6'(18'(i_cfg.eff_ids) - base)) - 64'd1;
        end else begin
            init_word = '0;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_init_idx   = r_init_idx;
        n_cur        = r_cur;
        n_next0      = r_next0;
        n_last       = r_last;
        n_cnt        = r_cnt;
        n_first      = r_first;
        n_rem        = r_rem;
        n_k          = r_k;
        n_count      = r_count;
        rd_en        = 1'b0;
        rd_addr      = '0;
        we           = 1'b0;
        wa           = '0;
        wd           = '0;
        pop          = 1'b0;
        fin          = 1'b0;
        do_scan      = 1'b0;
        do_part      = 1'b0;
        bit_sel      = 6'd0;
        n_granted_id = 14'd0;
        n_granted    = 1'b0;
        n_occupied   = 1'b0;

        unique case (r_state)
            S_INIT: begin
                we = 1'b1;
                wa = r_init_idx;
                wd = init_word;
                if (32'(r_init_idx) == NWORDS - 1) begin
                    n_state = S_IDLE;
                end else begin
                    n_init_idx = r_init_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && (!r_out_valid || i_out_ready)) begin
                    pop     = 1'b1;
                    n_cmd   = i_cmd;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (r_cmd.action == ACT_ALLOC) begin
                    if (r_cmd.n_zero) begin
                        fin = 1'b1;
                    end else if (r_cmd.chk) begin
                        rd_en   = 1'b1;
                        rd_addr = WIDX'(nfull - 9'd1);
                        n_state = S_CHK;
                    end else begin
                        do_scan = 1'b1;
                    end
                end else if (!r_cmd.in_range) begin
                    fin = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = WIDX'(r_cmd.tid[13:6]);
                    n_state = S_OP;
                end
            end
            S_CHK: begin
                if (refuse) begin
                    fin = 1'b1;
                end else begin
                    do_scan = 1'b1;
                end
            end
            S_MOD: begin
                // restoring remainder of (last_word + 1) by the full-word count
                n_rem = rem_step;
                n_k   = r_k - 4'd1;
                if (r_k == 4'd0) begin
                    n_next0 = WIDX'(rem_step);
                    rd_en   = 1'b1;
                    rd_addr = r_last;
                    n_cur   = r_last;
                    n_cnt   = 10'd1;
                    n_first = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rdata != 64'd0) begin
                    bit_sel      = lowest_bit(r_rdata);
                    we           = 1'b1;
                    wa           = r_cur;
                    wd           = r_rdata & ~(64'd1 << bit_sel);
                    n_count      = count_inc;
                    n_last       = r_cur;
                    fin          = 1'b1;
                    n_granted    = 1'b1;
                    n_granted_id = 14'({r_cur, bit_sel});
                end else if (r_cnt == 10'(nfull)) begin
                    do_part = 1'b1;
                end else begin
                    rd_en = 1'b1;
                    if (r_first) begin
                        rd_addr = r_next0;
                    end else if (next_lin == 16'(nfull)) begin
                        rd_addr = '0;
                    end else begin
                        rd_addr = WIDX'(next_lin);
                    end
                    n_cur   = rd_addr;
                    n_cnt   = r_cnt + 10'd1;
                    n_first = 1'b0;
                end
            end
            S_PART: begin
                if (masked != 64'd0) begin
                    bit_sel      = lowest_bit(masked);
                    we           = 1'b1;
                    wa           = WIDX'(nfull);
                    wd           = r_rdata & ~(64'd1 << bit_sel);
                    n_count      = count_inc;
                    n_last       = (nfull != 9'd0) ? WIDX'(nfull - 9'd1) : '0;
                    fin          = 1'b1;
                    n_granted    = 1'b1;
                    n_granted_id = 14'({nfull, bit_sel});
                end else begin
                    fin = 1'b1;
                end
            end
            S_OP: begin
                we  = (r_cmd.action != ACT_QUERY);
                wa  = WIDX'(r_cmd.tid[13:6]);
                fin = 1'b1;
                case (r_cmd.action)
                    ACT_FREE: begin
                        wd      = r_rdata | (64'd1 << r_cmd.tid[5:0]);
                        n_count = (r_count == 15'd0) ? r_count : r_count - 15'd1;
                    end
                    ACT_OCCUPY: wd = r_rdata & ~(64'd1 << r_cmd.tid[5:0]);
                    default:    n_occupied = !r_rdata[r_cmd.tid[5:0]];
                endcase
            end
            default: n_state = S_IDLE;
        endcase

        if (do_scan) begin
            if (nfull == 9'd0) begin
                do_part = 1'b1;
            end else if (lw1 > 16'(nfull)) begin
                n_rem   = 11'(lw1);
                n_k     = 4'd10;
                n_state = S_MOD;
            end else begin
                n_next0 = (lw1 == 16'(nfull)) ? '0 : WIDX'(lw1);
                rd_en   = 1'b1;
                rd_addr = r_last;
                n_cur   = r_last;
                n_cnt   = 10'd1;
                n_first = 1'b1;
                n_state = S_SCAN;
            end
        end

        if (do_part) begin
            if (partial_ok) begin
                rd_en   = 1'b1;
                rd_addr = WIDX'(nfull);
                n_state = S_PART;
            end else begin
                fin = 1'b1;
            end
        end

        if (fin) begin
            n_state = S_IDLE;
        end

        if (fin) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end

        if (i_init_req) begin
            n_state    = S_INIT;
            n_init_idx = '0;
            n_count    = '0;
            n_last     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_cur   <= n_cur;
        r_next0 <= n_next0;
        r_cnt   <= n_cnt;
        r_first <= n_first;
        r_rem   <= n_rem;
        r_k     <= n_k;
        if (fin) begin
            r_granted_id <= n_granted_id;
            r_granted    <= n_granted;
            r_occupied   <= n_occupied;
        end
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_idx  <= '0;
            r_last      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_idx  <= n_init_idx;
            r_last      <= n_last;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_init_busy  = (r_state == S_INIT);
    assign o_pop        = pop;
    assign o_out_valid  = r_out_valid;
    assign o_granted_id = r_granted_id;
    assign o_granted    = r_granted;
    assign o_occupied   = r_occupied;

endmodule

// ----- design/bitmap_id_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// Id allocator over a free bitmap of 64-bit words, one result per command.
// ----------------------------------------------------------------------------
// Commands arrive on the input channel (i_in_valid / o_in_ready) carrying
// action, target id and allocation limit; every command returns exactly one
// result on the output channel (o_out_valid / i_out_ready).
// A two-entry queue sits behind the input, so commands are taken while a
// result waits; the result register holds until the receiver takes it, and
// the back end does not start a new command until that register is free.
// Free, occupy and query read one bitmap word in the back end and write
// it back (query only reads). Allocate reads bitmap words one at a time:
// up to MAX_IDS/64 full words, plus the partial word, plus one word for the
// near-full check, and it first folds the scan start back below the limit
// when needed. The single read port of the bitmap memory sets that pace.
// After reset, and after each write of id_count, the bitmap is rebuilt one
// word per cycle and no command is taken meanwhile.
// Configuration is a plain write port: i_cfg_we, i_cfg_idx, i_cfg_data.
// ----------------------------------------------------------------------------
module bitmap_id_allocator #(
    parameter int MAX_IDS = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [13:0] i_target_id,
    input  logic [14:0] i_alloc_limit,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [13:0] o_granted_id,
    output logic        o_granted,
    output logic        o_occupied
);
    import bia_pkg::*;

    t_cmd front_cmd, fifo_cmd;
    t_cfg cfg;
    logic push, pop, full, fifo_valid, init_req, init_busy;

    bia_front #(.MAX_IDS(MAX_IDS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_target_id   (i_target_id),
        .i_alloc_limit (i_alloc_limit),
        .i_full        (full),
        .i_init_busy   (init_busy),
        .o_push        (push),
        .o_cmd         (front_cmd),
        .o_cfg         (cfg),
        .o_init_req    (init_req)
    );

    bia_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (fifo_valid),
        .o_cmd   (fifo_cmd)
    );

    bia_back #(.MAX_IDS(MAX_IDS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_init_req   (init_req),
        .o_init_busy  (init_busy),
        .i_cmd_valid  (fifo_valid),
        .i_cmd        (fifo_cmd),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_granted_id (o_granted_id),
        .o_granted    (o_granted),
        .o_occupied   (o_occupied)
    );

    // no command is taken while the bitmap is being rebuilt
    a_no_take_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        init_busy |-> !o_in_ready)
        else $error("command taken during bitmap rebuild");

    // a grant never carries a query answer
    a_grant_not_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_granted) |-> !o_occupied)
        else $error("granted and occupied both set");

    // a refused or non-allocate result reports id zero
    a_fail_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_granted) |-> (o_granted_id == 14'd0))
        else $error("nonzero id without grant");

    // the queue is never popped when empty
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> fifo_valid)
        else $error("pop from empty queue");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitmap id allocator: directed corner items,
// then random allocate/free/occupy/query traffic over several settings,
// with every result compared against a cycle-free model of the free bitmap.
// ----------------------------------------------------------------------------
module tb;
    import bia_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;   // index with no register behind it

    typedef struct {
        bit [13:0] id;
        bit        granted;
        bit        occupied;
    } t_result;

    class id_scoreboard;
        bit [63:0]   free_map[256];
        int unsigned used_cnt;
        int unsigned last_wd;
        int unsigned n_ids;
        int unsigned busy_thr;
        int unsigned headroom;
        t_result     expected_q[$];
        int          errors;

        function void rebuild();
            int unsigned n;
            n = (n_ids > 16384) ? 16384 : n_ids;
            for (int w = 0; w < 256; w++) begin
                if (w * 64 + 64 <= n) free_map[w] = '1;
                else if (w * 64 < n) free_map[w] = (64'd1 << (n - w * 64)) - 1;
                else free_map[w] = '0;
            end
            used_cnt = 0;
            last_wd  = 0;
        endfunction

        function void reset_state();
            n_ids    = 16384;
            busy_thr = 10240;
            headroom = 1024;
            errors   = 0;
            rebuild();
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_ID_COUNT: begin
                    n_ids = data[14:0];
                    rebuild();
                end
                CFG_BUSY_THR: busy_thr = data;
                CFG_HEADROOM: headroom = data;
                default: ;
            endcase
        endfunction

        function int unsigned low_bit(bit [63:0] v);
            for (int i = 0; i < 64; i++) if (v[i]) return i;
            return 63;
        endfunction

        function void take_bit(int unsigned wi, int unsigned b);
            free_map[wi][b] = 1'b0;
            if (used_cnt < 32767) used_cnt++;
        endfunction

        // accepted command: update the model and queue its result
        function t_result note(t_action act, bit [13:0] tid, bit [14:0] lim_in);
            t_result     r;
            int unsigned n, lim, nf, rem, idx, gap, b;
            bit [63:0]   w;
            bit          hit, refuse;
            r.id = 0;
            r.granted = 0;
            r.occupied = 0;
            n = (n_ids > 16384) ? 16384 : n_ids;
            if (act == ACT_ALLOC) begin
                if (n != 0) begin
                    lim = lim_in;
                    if (lim == 0 || lim > n) lim = n;
                    nf = lim / 64;
                    rem = lim % 64;
                    refuse = 0;
                    hit = 0;
                    if (lim > busy_thr && nf > 0 && free_map[nf - 1] == 0) begin
                        gap = (lim > used_cnt) ? lim - used_cnt : used_cnt - lim;
                        if ((gap < headroom && lim != n) || used_cnt == n) refuse = 1;
                    end
                    if (!refuse) begin
                        idx = last_wd;
                        for (int i = 0; i < nf && !hit; i++) begin
                            w = (idx < 256) ? free_map[idx] : '0;
                            if (w != 0) begin
                                b = low_bit(w);
                                take_bit(idx, b);
                                last_wd = idx;
                                r.id = 14'(idx * 64 + b);
                                hit = 1;
                            end
                            idx = (idx + 1) % nf;
                        end
                        // partial word above the last full one
                        if (!hit && rem != 0 && nf < 256) begin
                            w = free_map[nf];
                            if ((w & ((64'd1 << rem) - 1)) != 0) begin
                                b = low_bit(w);
                                take_bit(nf, b);
                                last_wd = (nf > 0) ? nf - 1 : 0;
                                r.id = 14'(nf * 64 + b);
                                hit = 1;
                            end
                        end
                        r.granted = hit;
                    end
                end
            end else if (tid < n) begin
                case (act)
                    ACT_FREE: begin
                        free_map[tid / 64][tid % 64] = 1'b1;
                        if (used_cnt > 0) used_cnt--;
                    end
                    ACT_OCCUPY: free_map[tid / 64][tid % 64] = 1'b0;
                    default: r.occupied = !free_map[tid / 64][tid % 64];
                endcase
            end
            expected_q.push_back(r);
            return r;
        endfunction

        function void check(bit [13:0] id, bit granted, bit occupied);
            t_result e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result id=%0d g=%0b o=%0b",
                                           id, granted, occupied);
                return;
            end
            e = expected_q.pop_front();
            if (e.id != id || e.granted != granted || e.occupied != occupied) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp id=%0d g=%0b o=%0b, got id=%0d g=%0b o=%0b",
                             e.id, e.granted, e.occupied, id, granted, occupied);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic [1:0]  i_action = '0;
    logic [13:0] i_target_id = '0;
    logic [14:0] i_alloc_limit = '0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic [13:0] o_granted_id;
    logic        o_granted;
    logic        o_occupied;

    id_scoreboard sb;
    int unsigned  live_ids[$];
    int unsigned  gap_pct;
    bit           rx_idle_on;
    int unsigned  stall_left;

    bitmap_id_allocator dut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // result side: check each transfer, stall in short bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check(o_granted_id, o_granted, o_occupied);
        if (stall_left > 0) begin
            i_out_ready <= 0;
            stall_left--;
        end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
            i_out_ready <= 0;
            stall_left = $urandom_range(0, 4);
        end else begin
            i_out_ready <= 1;
        end
    end

    task automatic send(t_action act, bit [13:0] tid, bit [14:0] lim);
        t_result r;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid    <= 1;
        i_action      <= act;
        i_target_id   <= tid;
        i_alloc_limit <= lim;
        do @(posedge i_clk); while (!o_in_ready);
        r = sb.note(act, tid, lim);
        if (r.granted) live_ids.push_back(r.id);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, data);
        if (idx == CFG_ID_COUNT) live_ids.delete();
    endtask

    // settings change only with the block idle; id_count goes last (rebuild)
    task automatic set_cfg(logic [15:0] thr, logic [15:0] hr, logic [15:0] ids);
        drain();
        repeat (20) @(posedge i_clk);
        write_cfg(CFG_BUSY_THR, thr);
        write_cfg(CFG_HEADROOM, hr);
        write_cfg(CFG_SPARE, 16'hffff);
        write_cfg(CFG_ID_COUNT, ids);
    endtask

    function automatic bit [14:0] pick_limit(int unsigned n);
        case ($urandom_range(0, 6))
            0: return 15'd0;
            1: return 15'($urandom_range(1, n + 10));
            2: return 15'($urandom_range(1, 70));
            3: return 15'($urandom_range(0, 32767));
            4: return 15'(n);
            5: return 15'(64 * $urandom_range(1, (n / 64) + 1));
            default: return 15'($urandom_range(n > 64 ? n - 64 : 1, n + 1));
        endcase
    endfunction

    task automatic run_random(int count, int unsigned n, int pause_at);
        int unsigned k, p;
        bit [13:0]   tid;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) drain();
            p = $urandom_range(0, 99);
            if (live_ids.size() > 0 && $urandom_range(0, 2) != 0) begin
                k = $urandom_range(0, live_ids.size() - 1);
                tid = 14'(live_ids[k]);
            end else if ($urandom_range(0, 3) == 0) begin
                tid = 14'($urandom_range(0, 16383));
            end else begin
                tid = 14'($urandom_range(0, n + 4));
            end
            if (p < 45) begin
                send(ACT_ALLOC, 14'($urandom), pick_limit(n));
            end else if (p < 75) begin
                // free a live id most of the time
                if (live_ids.size() > 0 && p < 68) begin
                    k = $urandom_range(0, live_ids.size() - 1);
                    tid = 14'(live_ids[k]);
                    live_ids.delete(k);
                end
                send(ACT_FREE, tid, 15'($urandom));
            end else if (p < 85) begin
                send(ACT_OCCUPY, tid, 15'($urandom));
            end else begin
                send(ACT_QUERY, tid, 15'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        gap_pct = 0;
        rx_idle_on = 0;
        stall_left = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed, reset settings
        send(ACT_QUERY, 14'd0, 15'd0);
        send(ACT_ALLOC, 14'd0, 15'd0);
        send(ACT_QUERY, 14'd0, 15'd0);
        send(ACT_ALLOC, 14'd0, 15'd1);
        send(ACT_ALLOC, 14'd0, 15'd63);
        send(ACT_ALLOC, 14'h3fff, 15'h7fff);
        send(ACT_OCCUPY, 14'd16383, 15'd0);
        send(ACT_QUERY, 14'd16383, 15'd0);
        send(ACT_ALLOC, 14'd0, 15'd16384);
        send(ACT_FREE, 14'd16383, 15'd0);
        send(ACT_FREE, 14'd16383, 15'd0);
        send(ACT_FREE, 14'd0, 15'd0);
        send(ACT_FREE, 14'd1, 15'd0);
        send(ACT_FREE, 14'd1, 15'd0);
        send(ACT_QUERY, 14'd16383, 15'd0);
        send(ACT_OCCUPY, 14'd8191, 15'd0);
        send(ACT_QUERY, 14'd8191, 15'd0);
        send(ACT_ALLOC, 14'd0, 15'd64);
        send(ACT_ALLOC, 14'd0, 15'd128);
        send(ACT_ALLOC, 14'd0, 15'd16320);

        // zero id count: everything out of range
        set_cfg(16'd0, 16'hffff, 16'd0);
        send(ACT_ALLOC, 14'd0, 15'd0);
        send(ACT_ALLOC, 14'd0, 15'd5);
        send(ACT_QUERY, 14'd0, 15'd0);
        send(ACT_FREE, 14'd3, 15'd0);
        send(ACT_OCCUPY, 14'd0, 15'd0);

        gap_pct = 25;
        rx_idle_on = 1;
        set_cfg(16'd0, 16'd10, 16'd100);
        run_random(350, 100, -1);

        set_cfg(16'hffff, 16'd0, 16'h7fff);
        run_random(350, 16384, 150);

        gap_pct = 0;
        set_cfg(16'd200, 16'd300, 16'd300);
        run_random(400, 300, -1);

        gap_pct = 40;
        set_cfg(16'd0, 16'd0, 16'd1);
        run_random(100, 1, -1);

        // last stretch without idling on either side
        gap_pct = 0;
        rx_idle_on = 0;
        set_cfg(16'd10240, 16'd1024, 16'd16384);
        run_random(625, 16384, -1);

        drain();
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[bitmap_id_allocator] OK");
        else
            $display("[bitmap_id_allocator] ERROR");
        $finish;
    end

    initial begin
        #20000000;
        $display("[bitmap_id_allocator] ERROR");
        $finish;
    end

endmodule
